// ===== hdl/vms_pkg.sv =====
// Shared types and constants for the vehicle motion step block.
package vms_pkg;

    localparam int VelW  = 16;
    localparam int PosW  = 24;
    localparam int SpdW  = 15;
    localparam int HalfW = 23;
    localparam int L2W   = 34;   // sum of three squared 16-bit magnitudes
    localparam int LenW  = 17;   // floor(sqrt) of an L2W value
    localparam int NumW  = 32;   // 2*mag*speed
    localparam int DenW  = 18;   // 2*len

    localparam logic [SpdW-1:0]  MaxSpeedRst = SpdW'(1024);
    localparam logic [HalfW-1:0] HalfRst     = {HalfW{1'b1}};

    typedef enum logic [2:0] {
        REG_MAX_SPEED   = 3'd0,
        REG_MIN_SPEED   = 3'd1,
        REG_HALF_WIDTH  = 3'd2,
        REG_HALF_HEIGHT = 3'd3,
        REG_HALF_DEPTH  = 3'd4,
        REG_EDGE_MODE   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_LOAD_VEL = 2'd1,
        KIND_LOAD_ALL = 2'd2,
        KIND_SPARE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EDGE_NONE   = 2'd0,
        EDGE_BOUNCE = 2'd1,
        EDGE_WRAP   = 2'd2,
        EDGE_SPARE  = 2'd3
    } edge_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,       // accumulate squares, one axis a cycle
        ST_CMP,      // decide on a rescale
        ST_SQRT,     // root running
        ST_DIV,      // one divide per axis
        ST_DIVW,
        ST_POS,      // advance position, one axis a cycle
        ST_OUT
    } state_t;

    // shared divider command and status
    typedef struct packed {
        logic            start;
        logic [NumW-1:0] num;
        logic [DenW-1:0] den;
    } div_cmd_t;

    typedef struct packed {
        logic            done;
        logic [NumW-1:0] quo;
    } div_sts_t;

endpackage

// ===== hdl/vehicle_motion_step.sv =====
// Top level: state, sequencer and shared root/divide units for one moving body.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tuser kind, s_tdata vel xyz, pos xyz
//  m_      | out | m_tvalid/m_tready | m_tdata pos xyz, vel xyz
//  cfg     | in  | cfg_we            | cfg_addr, cfg_data
//
// A full load (LOAD_ALL) is accepted, then the result offered; a tick or velocity load without
// rescale steps through three squares, a compare, three squares again, a compare and three
// position steps. Each rescale adds the root and three divides (one divider, shared).
// Worst case is two rescales. Reset is synchronous, clears the state, position, velocity and
// sequencing registers; s_tready is low while an item is in work or a result waits.
module vehicle_motion_step
    import vms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // kind
    input  logic [119:0] s_tdata,  // in_vel_x, in_vel_y, in_vel_z, in_pos_x, in_pos_y, in_pos_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [119:0] m_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [22:0] cfg_data
);
    // configuration
    logic [SpdW-1:0]  max_reg, min_reg;
    logic [HalfW-1:0] half_reg [3];
    logic [1:0]       mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg     <= MaxSpeedRst;
            min_reg     <= '0;
            half_reg[0] <= HalfRst;
            half_reg[1] <= HalfRst;
            half_reg[2] <= HalfRst;
            mode_reg    <= EDGE_NONE;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MAX_SPEED:   max_reg     <= cfg_data[SpdW-1:0];
                REG_MIN_SPEED:   min_reg     <= cfg_data[SpdW-1:0];
                REG_HALF_WIDTH:  half_reg[0] <= cfg_data;
                REG_HALF_HEIGHT: half_reg[1] <= cfg_data;
                REG_HALF_DEPTH:  half_reg[2] <= cfg_data;
                REG_EDGE_MODE:   mode_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic signed [PosW-1:0] pos_reg [3];
    logic signed [VelW-1:0] vel_reg [3];
    logic [L2W-1:0]  l2_reg;
    logic [1:0]      ax_reg;
    logic            pass_reg;     // 0 max check, 1 min check
    logic [SpdW-1:0] spd_reg;
    logic [LenW-1:0] len_reg;

    // shared units
    logic            sq_start, sq_done;
    logic [LenW-1:0] sq_root;
    div_cmd_t        dcmd;
    div_sts_t        dsts;

    vms_isqrt u_sqrt (.aclk, .aresetn, .start(sq_start), .rad(l2_reg),
                      .done(sq_done), .root(sq_root));
    vms_div   u_div  (.aclk, .aresetn, .cmd(dcmd), .sts(dsts));

    // per-axis helpers
    logic signed [VelW-1:0] cur_v;
    logic [VelW:0]          mag;
    logic [L2W-1:0]         sq;
    logic [L2W-1:0]         lim2;
    logic [NumW:0]          qr;
    logic signed [VelW:0]   sres;
    logic signed [VelW-1:0] scaled;
    logic signed [PosW:0]   psum;
    logic signed [PosW-1:0] padv, pfin, hpos, hneg;
    logic signed [VelW-1:0] vfin;
    logic [VelW+3:0]        dnum;
    logic [VelW:0]          dq;
    logic                   over, under;

    always_comb begin
        cur_v  = vel_reg[ax_reg];
        mag    = cur_v[VelW-1] ? (VelW+1)'(-$signed({cur_v[VelW-1], cur_v}))
                               : (VelW+1)'($signed({cur_v[VelW-1], cur_v}));
        sq     = L2W'(mag) * L2W'(mag);
        lim2   = L2W'(spd_reg) * L2W'(spd_reg);
        // quotient saturated on magnitude, then signed
        qr     = {1'b0, dsts.quo};
        if (qr > (NumW+1)'(32767)) sres = cur_v[VelW-1] ? -17'sd32768 : 17'sd32767;
        else sres = cur_v[VelW-1] ? -$signed({1'b0, qr[VelW-1:0]})
                                  :  $signed({1'b0, qr[VelW-1:0]});
        if (qr > (NumW+1)'(32768)) sres = cur_v[VelW-1] ? -17'sd32768 : 17'sd32767;
        scaled = sres[VelW-1:0];
        // position advance with saturation
        psum = (PosW+1)'(pos_reg[ax_reg]) + (PosW+1)'(cur_v);
        if (psum > (PosW+1)'(8388607)) padv = 24'sh7FFFFF;
        else if (psum < -(PosW+1)'(8388608)) padv = -24'sh800000;
        else padv = psum[PosW-1:0];
        hpos  = $signed({1'b0, half_reg[ax_reg]});
        hneg  = -hpos;
        over  = padv > hpos;
        under = padv < hneg;
        // round(-0.8 v): (8m+5)/10 via reciprocal multiply, m <= 32768
        dnum  = (VelW+4)'(mag) * 8 + 5;
        dq    = (VelW+1)'((40'(dnum) * 40'd838861) >> 23);
        pfin  = padv;
        vfin  = cur_v;
        unique case (edge_t'(mode_reg))
            EDGE_BOUNCE: begin
                if (over || under) begin
                    pfin = over ? hpos : hneg;
                    vfin = cur_v[VelW-1] ? VelW'(dq) : VelW'(-$signed({1'b0, dq}));
                end
            end
            EDGE_WRAP: begin
                if (over) pfin = hneg;
                else if (under) pfin = hpos;
                if (ax_reg == 2'd2) pfin = '0;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next =
                (kind_t'(s_tuser) == KIND_LOAD_ALL) ? ST_OUT : ST_SQ;
            ST_SQ:   if (ax_reg == 2'd2) state_next = ST_CMP;
            ST_CMP: begin
                if (!pass_reg ? (l2_reg > lim2)
                              : (l2_reg != '0 && l2_reg < lim2)) state_next = ST_SQRT;
                else if (pass_reg) state_next = ST_POS;
                else state_next = ST_SQ;
            end
            ST_SQRT: if (sq_done) state_next = ST_DIV;
            ST_DIV:  state_next = ST_DIVW;
            ST_DIVW: if (dsts.done) state_next = (ax_reg == 2'd2) ?
                         (pass_reg ? ST_POS : ST_SQ) : ST_DIV;
            ST_POS:  if (ax_reg == 2'd2) state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // unit commands
    always_comb begin
        sq_start  = (state_reg == ST_CMP) && (state_next == ST_SQRT);
        dcmd.start = (state_reg == ST_DIV);
        dcmd.num   = NumW'({mag, 1'b0}) * NumW'(spd_reg);
        dcmd.den   = {len_reg, 1'b0};
        dcmd.num   = dcmd.num + NumW'(len_reg);
        s_tready   = (state_reg == ST_IDLE);
        m_tvalid   = (state_reg == ST_OUT);
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            ax_reg   <= '0;
            pass_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    ax_reg   <= '0;
                    pass_reg <= 1'b0;
                    l2_reg   <= '0;
                    spd_reg  <= max_reg;
                    if (kind_t'(s_tuser) == KIND_LOAD_VEL ||
                        kind_t'(s_tuser) == KIND_LOAD_ALL) begin
                        vel_reg[0] <= s_tdata[15:0];
                        vel_reg[1] <= s_tdata[31:16];
                        vel_reg[2] <= s_tdata[47:32];
                    end
                    if (kind_t'(s_tuser) == KIND_LOAD_ALL) begin
                        pos_reg[0] <= s_tdata[71:48];
                        pos_reg[1] <= s_tdata[95:72];
                        pos_reg[2] <= s_tdata[119:96];
                    end
                end
                ST_SQ: begin
                    l2_reg <= l2_reg + sq;
                    ax_reg <= ax_reg + 2'd1;
                    if (ax_reg == 2'd2) ax_reg <= '0;
                end
                ST_CMP: begin
                    if (state_next == ST_SQ) begin
                        pass_reg <= 1'b1;
                        spd_reg  <= min_reg;
                        l2_reg   <= '0;
                    end
                end
                ST_SQRT: if (sq_done) len_reg <= sq_root;
                ST_DIVW: if (dsts.done) begin
                    vel_reg[ax_reg] <= scaled;
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                    if (ax_reg == 2'd2 && !pass_reg) begin
                        pass_reg <= 1'b1;
                        spd_reg  <= min_reg;
                        l2_reg   <= '0;
                    end
                end
                ST_POS: begin
                    pos_reg[ax_reg] <= pfin;
                    vel_reg[ax_reg] <= vfin;
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    assign m_tdata = {vel_reg[2], vel_reg[1], vel_reg[0],
                      pos_reg[2], pos_reg[1], pos_reg[0]};
endmodule

// ===== hdl/vms_isqrt.sv =====
// Bit-pair iterative integer square root, two bits of radicand a cycle.
module vms_isqrt
    import vms_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [L2W-1:0]  rad,
    output logic            done,
    output logic [LenW-1:0] root
);
    localparam int Steps = L2W / 2;

    logic [L2W-1:0]          x_reg, x_next;
    logic [L2W-1:0]          r_reg, r_next;
    logic [L2W-1:0]          b_reg, b_next;
    logic                    busy_reg, busy_next;
    logic [$clog2(Steps+1)-1:0] n_reg, n_next;
    logic [L2W-1:0]          trial;

    // one restoring step per cycle
    always_comb begin
        trial     = r_reg + b_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        n_next    = n_reg;
        done      = 1'b0;
        if (start) begin
            x_next    = rad;
            r_next    = '0;
            b_next    = L2W'(1) << (L2W - 2);
            busy_next = 1'b1;
            n_next    = '0;
        end else if (busy_reg) begin
            if (x_reg >= trial) begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + b_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
            n_next = n_reg + 1'b1;
            if (n_reg == ($clog2(Steps+1))'(Steps - 1)) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        x_reg <= x_next;
        r_reg <= r_next;
        b_reg <= b_next;
        n_reg <= n_next;
    end

    assign root = r_next[LenW-1:0];
endmodule

// ===== hdl/vms_div.sv =====
// Shared restoring divider, one quotient bit a cycle.
module vms_div
    import vms_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_cmd_t cmd,
    output div_sts_t sts
);
    logic [NumW-1:0]          q_reg, q_next;
    logic [DenW:0]            rem_reg, rem_next;
    logic [DenW-1:0]          d_reg, d_next;
    logic                     busy_reg, busy_next;
    logic [$clog2(NumW)-1:0]  n_reg, n_next;
    logic [DenW:0]            sh;

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        busy_next = busy_reg;
        n_next    = n_reg;
        sts.done  = 1'b0;
        sh        = {rem_reg[DenW-1:0], q_reg[NumW-1]};
        if (cmd.start) begin
            q_next    = cmd.num;
            rem_next  = '0;
            d_next    = cmd.den;
            busy_next = 1'b1;
            n_next    = '0;
        end else if (busy_reg) begin
            if (sh >= {1'b0, d_reg}) begin
                rem_next = sh - {1'b0, d_reg};
                q_next   = {q_reg[NumW-2:0], 1'b1};
            end else begin
                rem_next = sh;
                q_next   = {q_reg[NumW-2:0], 1'b0};
            end
            n_next = n_reg + 1'b1;
            if (n_reg == ($clog2(NumW))'(NumW - 1)) begin
                busy_next = 1'b0;
                sts.done  = 1'b1;
            end
        end
        sts.quo = q_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        n_reg   <= n_next;
    end
endmodule

// ===== bench/vms_checker.sv =====
// Checker for the vehicle motion step block: result prediction and comparison.
module vms_checker
    import vms_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [1:0]   s_tuser,
    input  logic [119:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [22:0]  cfg_data,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted configuration and body state
    logic [SpdW-1:0]  lim_max, lim_min;
    logic [HalfW-1:0] box [3];
    edge_t            edge_rule;
    longint           body_pos [3];
    longint           body_vel [3];
    logic [119:0]     motion_q [$];

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint root_floor(longint x);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - r - b;
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint speed_sq();
        return body_vel[0] * body_vel[0] + body_vel[1] * body_vel[1]
             + body_vel[2] * body_vel[2];
    endfunction

    // scale velocity to a target speed, rounding magnitudes half away from zero
    function automatic void scale_to(longint l2, longint spd);
        longint len, mag, q;
        len = root_floor(l2);
        if (len == 0) return;
        for (int i = 0; i < 3; i++) begin
            mag = body_vel[i] < 0 ? -body_vel[i] : body_vel[i];
            q = (2 * mag * spd + len) / (2 * len);
            body_vel[i] = clampv(body_vel[i] < 0 ? -q : q, -32768, 32767);
        end
    endfunction

    // bounce damping by -0.8
    function automatic longint damped(longint v);
        longint m, q;
        m = v < 0 ? -v : v;
        q = (8 * m + 5) / 10;
        return v >= 0 ? -q : q;
    endfunction

    function automatic void advance_body();
        longint l2, h;
        l2 = speed_sq();
        if (l2 > longint'(lim_max) * lim_max) scale_to(l2, lim_max);
        l2 = speed_sq();
        if (l2 > 0 && l2 < longint'(lim_min) * lim_min) scale_to(l2, lim_min);
        for (int i = 0; i < 3; i++) begin
            body_pos[i] = clampv(body_pos[i] + body_vel[i], -8388608, 8388607);
            h = longint'(box[i]);
            if (edge_rule == EDGE_BOUNCE) begin
                if (body_pos[i] > h || body_pos[i] < -h) begin
                    body_pos[i] = body_pos[i] > h ? h : -h;
                    body_vel[i] = damped(body_vel[i]);
                end
            end else if (edge_rule == EDGE_WRAP) begin
                if (body_pos[i] > h) body_pos[i] = -h;
                else if (body_pos[i] < -h) body_pos[i] = h;
            end
        end
        if (edge_rule == EDGE_WRAP) body_pos[2] = 0;
    endfunction

    function automatic logic [119:0] pack_body();
        logic [119:0] r;
        for (int i = 0; i < 3; i++) begin
            r[24*i +: 24]      = body_pos[i][23:0];
            r[72 + 16*i +: 16] = body_vel[i][15:0];
        end
        return r;
    endfunction

    assign pending = motion_q.size();

    always @(posedge aclk) begin
        logic [119:0] want;
        kind_t k;
        int errs;
        if (!aresetn) begin
            lim_max <= MaxSpeedRst;
            lim_min <= '0;
            for (int i = 0; i < 3; i++) box[i] <= HalfRst;
            edge_rule <= EDGE_NONE;
            for (int i = 0; i < 3; i++) begin
                body_pos[i] = 0;
                body_vel[i] = 0;
            end
            motion_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_MAX_SPEED:   lim_max <= cfg_data[SpdW-1:0];
                    REG_MIN_SPEED:   lim_min <= cfg_data[SpdW-1:0];
                    REG_HALF_WIDTH:  box[0] <= cfg_data;
                    REG_HALF_HEIGHT: box[1] <= cfg_data;
                    REG_HALF_DEPTH:  box[2] <= cfg_data;
                    REG_EDGE_MODE:   edge_rule <= edge_t'(cfg_data[1:0]);
                    default: ;
                endcase
            end
            // accepted input item
            if (s_tvalid && s_tready) begin
                k = kind_t'(s_tuser);
                if (k == KIND_LOAD_VEL || k == KIND_LOAD_ALL)
                    for (int i = 0; i < 3; i++)
                        body_vel[i] = longint'(signed'(s_tdata[16*i +: 16]));
                if (k == KIND_LOAD_ALL)
                    for (int i = 0; i < 3; i++)
                        body_pos[i] = longint'(signed'(s_tdata[48 + 24*i +: 24]));
                else
                    advance_body();
                motion_q = {motion_q, pack_body()};
            end
            // accepted result item
            if (m_tvalid && m_tready) begin
                errs = 0;
                if (motion_q.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, m_tdata);
                    errs = 1;
                end else begin
                    want = motion_q.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        if (f < 3 && want[24*f +: 24] !== m_tdata[24*f +: 24]) begin
                            $display("%0t: pos[%0d] expected %h actual %h", $time, f,
                                     want[24*f +: 24], m_tdata[24*f +: 24]);
                            errs = errs + 1;
                        end
                        if (f >= 3 && want[72 + 16*(f-3) +: 16]
                                !== m_tdata[72 + 16*(f-3) +: 16]) begin
                            $display("%0t: vel[%0d] expected %h actual %h", $time, f - 3,
                                     want[72 + 16*(f-3) +: 16], m_tdata[72 + 16*(f-3) +: 16]);
                            errs = errs + 1;
                        end
                    end
                end
                fail_count <= fail_count + errs;
            end
        end
    end
endmodule

// ===== bench/tb.sv =====
// Testbench top for the vehicle motion step block: stimulus, stalls and verdict.
module tb;
    import vms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0, s_tready;
    logic [1:0]   s_tuser = '0;
    logic [119:0] s_tdata = '0;
    logic         m_tvalid, m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [22:0]  cfg_data = '0;
    int           fail_count, pending;
    int           send_idle = 0, recv_stall = 0, hold_off = 0;
    logic         hold_go = 1'b0, hold_done = 1'b0;
    longint       cycle_no = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    vehicle_motion_step dut (.*);
    vms_checker chk (.*);

    // run guard
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > 3000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge aclk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_off  <= 400;
            m_tready  <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic write_reg(cfg_reg_t r, logic [22:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= r;
        cfg_data <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // offer one item, hold it until accepted
    task automatic send_motion(kind_t k, logic [119:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [119:0] rand_motion(bit wide);
        logic [119:0] d;
        d = 120'({$urandom, $urandom, $urandom, $urandom});
        if (!wide)
            for (int i = 0; i < 3; i++)
                d[16*i +: 16] = 16'($signed($urandom_range(1200)) - 600);
        return d;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic random_phase(int n, int si, int rs);
        kind_t k;
        send_idle = si;
        recv_stall = rs;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0:       k = KIND_LOAD_ALL;
                1, 2, 3: k = KIND_LOAD_VEL;
                4:       k = KIND_SPARE;
                default: k = KIND_TICK;
            endcase
            send_motion(k, rand_motion($urandom_range(3) == 0));
        end
        drain();
    endtask

    task automatic set_limits(int mx, int mn, int hw, int hh, int hd, edge_t e);
        write_reg(REG_MAX_SPEED, 23'(mx));
        write_reg(REG_MIN_SPEED, 23'(mn));
        write_reg(REG_HALF_WIDTH, 23'(hw));
        write_reg(REG_HALF_HEIGHT, 23'(hh));
        write_reg(REG_HALF_DEPTH, 23'(hd));
        write_reg(REG_EDGE_MODE, 23'(e));
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes, every kind, reset limits
        send_motion(KIND_TICK, '0);
        send_motion(KIND_LOAD_ALL, {24'h7FFFFF, 24'h800000, 24'h000000,
                                    16'h7FFF, 16'h8000, 16'h0001});
        send_motion(KIND_TICK, '0);
        send_motion(KIND_LOAD_VEL, {72'h0, 16'h8000, 16'h8000, 16'h8000});
        send_motion(KIND_SPARE, '0);
        send_motion(KIND_LOAD_VEL, {72'h0, 16'h0000, 16'h0000, 16'h0000});
        send_motion(KIND_TICK, '0);
        send_motion(KIND_LOAD_ALL, {120{1'b1}});
        send_motion(KIND_TICK, '0);
        drain();
        // bounce in a small box, min above max
        set_limits(100, 300, 1000, 2000, 500, EDGE_BOUNCE);
        send_motion(KIND_LOAD_ALL, {24'd0, 24'd1990, 24'd990, 16'hFF00, 16'h0100, 16'h0100});
        repeat (4) send_motion(KIND_TICK, '0);
        send_motion(KIND_LOAD_VEL, {72'h0, 16'h0000, 16'h0000, 16'h0001});
        send_motion(KIND_TICK, '0);
        drain();
        // wrap, zero box, zero limits
        set_limits(0, 0, 0, 0, 0, EDGE_WRAP);
        send_motion(KIND_LOAD_ALL, {24'd5, 24'd5, 24'd5, 16'h0005, 16'h0005, 16'h0005});
        send_motion(KIND_TICK, '0);
        drain();
        set_limits(32767, 32767, 8388607, 8388607, 8388607, EDGE_SPARE);
        send_motion(KIND_LOAD_VEL, {72'h0, 16'h0003, 16'h8000, 16'h0001});
        send_motion(KIND_TICK, '0);
        drain();

        // long receiver hold-off while items keep coming
        hold_go = 1'b1;
        random_phase(20, 0, 0);

        set_limits(800, 100, 4000, 3000, 2000, EDGE_BOUNCE);
        random_phase(460, 0, 0);
        set_limits(1500, 0, 6000, 6000, 6000, EDGE_WRAP);
        random_phase(450, 83, 0);
        set_limits(32767, 400, 100000, 8388607, 50000, EDGE_NONE);
        random_phase(450, 0, 83);
        set_limits(600, 200, 2500, 2500, 2500, EDGE_BOUNCE);
        random_phase(450, 30, 30);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/vms_pkg.sv
hdl/vms_isqrt.sv
hdl/vms_div.sv
hdl/vehicle_motion_step.sv
bench/vms_checker.sv
bench/tb.sv
